// File: src/mtep_pkg.sv
// shared types and constants for the midi track event parser
// no dependencies

package mtep_pkg;

	localparam int TRACKS_DEF = 16;

	localparam logic [3:0] PH_ENDED     = 4'd0;
	localparam logic [3:0] PH_DELTA     = 4'd1;
	localparam logic [3:0] PH_EVENT     = 4'd2;
	localparam logic [3:0] PH_DATA1     = 4'd3;
	localparam logic [3:0] PH_DATA2     = 4'd4;
	localparam logic [3:0] PH_META_TYPE = 4'd5;
	localparam logic [3:0] PH_META_LEN  = 4'd6;
	localparam logic [3:0] PH_SYSEX_LEN = 4'd7;
	localparam logic [3:0] PH_SKIP      = 4'd8;
	localparam logic [3:0] PH_TEMPO     = 4'd9;

	localparam logic [1:0] KIND_DELAY = 2'd0;
	localparam logic [1:0] KIND_MSG   = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	localparam logic [1:0] REG_TICKS = 2'd0;
	localparam logic [1:0] REG_TEMPO = 2'd1;
	localparam logic [1:0] REG_VOL   = 2'd2;

	localparam logic [7:0]  META_ESC   = 8'hFF;
	localparam logic [7:0]  META_TEMPO = 8'h51;
	localparam logic [7:0]  META_EOT   = 8'h2F;
	localparam logic [3:0]  CMD_SYS    = 4'hF;
	localparam logic [3:0]  CMD_PROG   = 4'hC;
	localparam logic [3:0]  CMD_PRESS  = 4'hD;
	localparam logic [3:0]  CMD_CTRL   = 4'hB;
	localparam logic [7:0]  CC_VOLUME  = 8'h07;
	localparam logic [7:0]  DATA_MAX   = 8'h7F;
	localparam logic [23:0] TEMPO_RST  = 24'd500000;
	localparam logic [9:0]  MS_PER_S   = 10'd1000;

	typedef struct packed {
		logic [3:0]  phase;
		logic [31:0] accum;
		logic [31:0] skip;
		logic [7:0]  run_st;
		logic [7:0]  ev_st;
		logic [7:0]  meta;
		logic [7:0]  held;
		logic [23:0] tempo;
	} trk_state_t;

	localparam trk_state_t TRK_RESET = '{
		phase: PH_ENDED, accum: 32'd0, skip: 32'd0, run_st: 8'd0,
		ev_st: 8'd0, meta: 8'd0, held: 8'd0, tempo: TEMPO_RST
	};

endpackage

// File: src/mtep_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module mtep_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/midi_track_event_parser_unit.sv
// midi track event parser: per-track smf event decoding with delay in ms
// depends on mtep_pkg and mtep_ram
//
// sequencing: a request is latched in idle and decoded in proc; a message or
// end result then goes through emit into the result register, and a byte with
// no result returns the block to idle; a completed delta passes through mul1,
// mul2 and chk, then the shared restoring divider (one quotient bit a cycle)
// unless saturated or the divisor is zero, then emit; a result waits while the
// previous one is still held by the receiver; the block is busy while working
// and takes a new request only once it is back in idle
// reset: arst_n clears control state and all track valid bits; a track whose
// valid bit is clear reads as ended with tempo 500000
module midi_track_event_parser_unit
	import mtep_pkg::*;
#(
	parameter int TRACKS = TRACKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// byte requests
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  track,
	input  logic [7:0]  data_byte,
	input  logic        track_start,
	// results
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [3:0]  track_out,
	output logic [7:0]  status_code,
	output logic [7:0]  first_data,
	output logic [7:0]  second_data,
	output logic        has_second,
	output logic [31:0] delay_ms
);

	localparam int AW = TRACKS > 1 ? $clog2(TRACKS) : 1;
	localparam int SW = $bits(trk_state_t);

	// sequencer codes
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PROC = 3'd1;
	localparam logic [2:0] S_MUL1 = 3'd2;
	localparam logic [2:0] S_MUL2 = 3'd3;
	localparam logic [2:0] S_CHK  = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	logic [2:0] state_q;

	// config registers
	logic [14:0] ticks_q;
	logic [10:0] tscale_q;
	logic [11:0] vscale_q;

	// latched request
	logic [AW-1:0] addr_q;
	logic [3:0]    trk_q;
	logic [7:0]    byte_q;
	logic          start_q;
	logic          inrange_q;

	// per-track valid bits
	logic [TRACKS-1:0] vld_q;

	// track state ram
	logic [AW+3:0]  trk_ext;
	logic [AW-1:0]  addr_in;
	logic           ram_we;
	logic [SW-1:0]  ram_rdata;
	trk_state_t     cur, nxt;

	// pending result
	logic [1:0]  res_kind_q;
	logic [7:0]  res_st_q, res_d1_q, res_d2_q;
	logic        res_two_q;
	logic        load_out;

	// delay arithmetic
	logic [31:0] delta_q;
	logic [23:0] tempo_q;
	logic [55:0] prod_q;
	logic [24:0] den1_q;
	logic [63:0] num_q;
	logic [35:0] den_q;
	logic [36:0] rem_q;
	logic [31:0] quo_q;
	logic [4:0]  cnt_q;
	logic [36:0] trial;
	logic        fits;

	// combinational decode results
	logic        emit, need_div, msg_two;
	logic [1:0]  ekind;
	logic [7:0]  msg_st, msg_d1, msg_d2, d2_out;
	logic [31:0] acc7;
	logic [23:0] acc8;
	logic [31:0] skip_dec;
	logic [19:0] vol_prod;

	assign trk_ext  = {{AW{1'b0}}, track};
	assign addr_in  = trk_ext[AW-1:0];
	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	mtep_ram #(
		.WIDTH(SW),
		.DEPTH(TRACKS)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (nxt),
		.raddr (addr_in),
		.rdata (ram_rdata)
	);

	// a fresh start or a never-written track reads as reset state
	always_comb begin
		if (start_q) begin
			cur = TRK_RESET;
			cur.phase = PH_DELTA;
		end else if (vld_q[addr_q]) begin
			cur = trk_state_t'(ram_rdata);
		end else begin
			cur = TRK_RESET;
		end
	end

	assign acc7     = {cur.accum[24:0], byte_q[6:0]};
	assign acc8     = {cur.accum[15:0], byte_q};
	assign skip_dec = cur.skip - 32'd1;

	// event decode for one byte
	always_comb begin
		nxt      = cur;
		emit     = 1'b0;
		need_div = 1'b0;
		ekind    = KIND_MSG;
		msg_st   = cur.ev_st;
		msg_d1   = byte_q;
		msg_d2   = 8'd0;
		msg_two  = 1'b0;
		case (cur.phase)
			PH_DELTA: begin
				if (!byte_q[7]) begin
					need_div  = 1'b1;
					nxt.accum = 32'd0;
					nxt.phase = PH_EVENT;
				end else begin
					nxt.accum = acc7;
				end
			end
			PH_EVENT: begin
				if (byte_q == META_ESC) begin
					nxt.phase = PH_META_TYPE;
				end else if (byte_q[7:4] == CMD_SYS) begin
					nxt.accum = 32'd0;
					nxt.phase = PH_SYSEX_LEN;
				end else if (byte_q[7]) begin
					nxt.run_st = byte_q;
					nxt.ev_st  = byte_q;
					nxt.phase  = PH_DATA1;
				end else begin
					nxt.ev_st = cur.run_st;
					nxt.held  = byte_q;
					msg_st    = cur.run_st;
					if (cur.run_st[7:4] != CMD_PROG && cur.run_st[7:4] != CMD_PRESS) begin
						nxt.phase = PH_DATA2;
					end else begin
						emit      = 1'b1;
						nxt.phase = PH_DELTA;
					end
				end
			end
			PH_DATA1: begin
				nxt.held = byte_q;
				if (cur.ev_st[7:4] != CMD_PROG && cur.ev_st[7:4] != CMD_PRESS) begin
					nxt.phase = PH_DATA2;
				end else begin
					emit      = 1'b1;
					nxt.phase = PH_DELTA;
				end
			end
			PH_DATA2: begin
				emit      = 1'b1;
				msg_d1    = cur.held;
				msg_d2    = byte_q;
				msg_two   = 1'b1;
				nxt.phase = PH_DELTA;
			end
			PH_META_TYPE: begin
				nxt.meta  = byte_q;
				nxt.accum = 32'd0;
				nxt.phase = PH_META_LEN;
			end
			PH_META_LEN: begin
				if (!byte_q[7]) begin
					nxt.accum = 32'd0;
					if (cur.meta == META_TEMPO) begin
						nxt.skip  = 32'd3;
						nxt.phase = PH_TEMPO;
					end else if (cur.meta == META_EOT) begin
						emit      = 1'b1;
						ekind     = KIND_END;
						nxt.phase = PH_ENDED;
					end else begin
						nxt.skip  = acc7;
						nxt.phase = (acc7 == 32'd0) ? PH_DELTA : PH_SKIP;
					end
				end else begin
					nxt.accum = acc7;
				end
			end
			PH_SYSEX_LEN: begin
				if (!byte_q[7]) begin
					nxt.accum = 32'd0;
					nxt.skip  = acc7;
					nxt.phase = (acc7 == 32'd0) ? PH_DELTA : PH_SKIP;
				end else begin
					nxt.accum = acc7;
				end
			end
			PH_SKIP: begin
				nxt.skip = skip_dec;
				if (skip_dec == 32'd0) begin
					nxt.phase = PH_DELTA;
				end
			end
			PH_TEMPO: begin
				nxt.skip = skip_dec;
				if (skip_dec == 32'd0) begin
					nxt.tempo = acc8;
					nxt.accum = 32'd0;
					nxt.phase = PH_DELTA;
				end else begin
					nxt.accum = {8'd0, acc8};
				end
			end
			default: begin
				// ended track: byte dropped
			end
		endcase
	end

	// controller 7 volume scaling, clamped to the data range
	assign vol_prod = 20'(msg_d2) * 20'(vscale_q);
	always_comb begin
		d2_out = msg_d2;
		if (msg_two && msg_st[7:4] == CMD_CTRL && msg_d1 == CC_VOLUME) begin
			d2_out = (vol_prod[19:8] > 12'(DATA_MAX)) ? DATA_MAX : vol_prod[15:8];
		end
	end

	assign ram_we = (state_q == S_PROC) && inrange_q;

	// result register loads once the previous result has left
	assign load_out = (state_q == S_EMIT) && (!out_valid || out_ready);

	// one restoring divide step: shift in the next numerator bit
	assign trial = {rem_q[35:0], quo_q[31]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			vld_q     <= '0;
			out_valid <= 1'b0;
			ticks_q   <= 15'd96;
			tscale_q  <= 11'd256;
			vscale_q  <= 12'd256;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_TICKS: ticks_q  <= cfg_data[14:0];
					REG_TEMPO: tscale_q <= cfg_data[10:0];
					REG_VOL:   vscale_q <= cfg_data[11:0];
					default: ;
				endcase
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PROC;
					end
				end
				S_PROC: begin
					if (!inrange_q) begin
						state_q <= S_IDLE;
					end else begin
						vld_q[addr_q] <= 1'b1;
						if (need_div) begin
							state_q <= S_MUL1;
						end else if (emit) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_CHK;
				S_CHK: begin
					if (den_q == 36'd0 || {4'd0, num_q[63:32]} >= den_q) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == 5'd31) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				addr_q    <= addr_in;
				trk_q     <= track;
				byte_q    <= data_byte;
				start_q   <= track_start;
				inrange_q <= 32'(track) < TRACKS;
			end
			S_PROC: begin
				res_kind_q <= need_div ? KIND_DELAY : ekind;
				res_st_q   <= msg_st;
				res_d1_q   <= msg_d1;
				res_d2_q   <= d2_out;
				res_two_q  <= msg_two;
				delta_q    <= acc7;
				tempo_q    <= cur.tempo;
			end
			S_MUL1: begin
				prod_q <= 56'(delta_q) * 56'(tempo_q);
				den1_q <= 25'(ticks_q) * 25'(MS_PER_S);
			end
			S_MUL2: begin
				num_q <= {prod_q, 8'd0};
				den_q <= 36'(den1_q) * 36'(tscale_q);
			end
			S_CHK: begin
				rem_q <= {5'd0, num_q[63:32]};
				quo_q <= num_q[31:0];
				cnt_q <= 5'd0;
				if (den_q == 36'd0 || {4'd0, num_q[63:32]} >= den_q) begin
					quo_q <= 32'hFFFF_FFFF;
				end
			end
			S_DIV: begin
				rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
				quo_q <= {quo_q[30:0], fits};
				cnt_q <= cnt_q + 5'd1;
			end
			S_EMIT: begin
				if (load_out) begin
					kind      <= res_kind_q;
					track_out <= trk_q;
					if (res_kind_q == KIND_MSG) begin
						status_code <= res_st_q;
						first_data  <= res_d1_q;
						second_data <= res_two_q ? res_d2_q : 8'd0;
						has_second  <= res_two_q;
					end else begin
						status_code <= 8'd0;
						first_data  <= 8'd0;
						second_data <= 8'd0;
						has_second  <= 1'b0;
					end
					delay_ms <= (res_kind_q == KIND_DELAY) ? quo_q : 32'd0;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: dv/mtep_checker.sv
// checker for the midi track event parser: watches the channels, predicts and compares
// depends on mtep_pkg
`timescale 1ns / 1ps

module mtep_checker
	import mtep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [3:0]  track,
	input  logic [7:0]  data_byte,
	input  logic        track_start,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  kind,
	input  logic [3:0]  track_out,
	input  logic [7:0]  status_code,
	input  logic [7:0]  first_data,
	input  logic [7:0]  second_data,
	input  logic        has_second,
	input  logic [31:0] delay_ms,
	output int          pending,
	output int          errors
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  trk;
		logic [7:0]  st;
		logic [7:0]  d1;
		logic [7:0]  d2;
		logic        two;
		logic [31:0] dly;
	} event_res_t;

	event_res_t  expected_q[$];

	logic [3:0]  ph   [16];
	logic [31:0] acc  [16];
	logic [31:0] skp  [16];
	logic [7:0]  rs   [16];
	logic [7:0]  es   [16];
	logic [7:0]  mk   [16];
	logic [7:0]  hd   [16];
	logic [23:0] tmp  [16];
	logic [14:0] tpq;
	logic [10:0] tsc;
	logic [11:0] vsc;

	function automatic logic [31:0] delay_ms_of(logic [31:0] d, logic [23:0] tu);
		logic [63:0] num, den, q;
		num = 64'(d) * 64'(tu) * 64'd256;
		den = 64'(tpq) * 64'd1000 * 64'(tsc);
		if (den == 0)
			return 32'hFFFF_FFFF;
		q = num / den;
		return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	function automatic logic two_data(logic [7:0] st);
		return st[7:4] != CMD_PROG && st[7:4] != CMD_PRESS;
	endfunction

	function automatic event_res_t channel_msg(logic [3:0] t, logic [7:0] st, logic [7:0] d1,
			logic [7:0] d2, logic two);
		event_res_t r;
		logic [19:0] v;
		r = '0;
		r.kind = KIND_MSG;
		r.trk = t;
		r.st = st;
		r.d1 = d1;
		r.two = two;
		v = 20'(d2);
		if (two && st[7:4] == CMD_CTRL && d1 == CC_VOLUME) begin
			v = (20'(d2) * 20'(vsc)) >> 8;
			if (v > 20'(DATA_MAX))
				v = 20'(DATA_MAX);
		end
		r.d2 = two ? v[7:0] : 8'd0;
		return r;
	endfunction

	// length of a meta or sysex body decides whether to skip
	task automatic take_length(logic [3:0] t, logic [31:0] len);
		skp[t] = len;
		ph[t] = (len == 0) ? PH_DELTA : PH_SKIP;
	endtask

	task automatic predict_byte(logic [3:0] t, logic [7:0] b, logic s);
		event_res_t r;
		logic [31:0] len;
		r = '0;
		r.trk = t;
		if (s) begin
			ph[t] = PH_DELTA; acc[t] = 0; skp[t] = 0; rs[t] = 0;
			es[t] = 0; mk[t] = 0; hd[t] = 0; tmp[t] = TEMPO_RST;
		end
		case (ph[t])
			PH_DELTA: begin
				acc[t] = (acc[t] << 7) | 32'(b[6:0]);
				if (!b[7]) begin
					r.kind = KIND_DELAY;
					r.dly = delay_ms_of(acc[t], tmp[t]);
					expected_q.push_back(r);
					acc[t] = 0;
					ph[t] = PH_EVENT;
				end
			end
			PH_EVENT: begin
				if (b == META_ESC) begin
					ph[t] = PH_META_TYPE;
				end else if (b[7:4] == CMD_SYS) begin
					acc[t] = 0;
					ph[t] = PH_SYSEX_LEN;
				end else if (b[7]) begin
					rs[t] = b;
					es[t] = b;
					ph[t] = PH_DATA1;
				end else begin
					es[t] = rs[t];
					hd[t] = b;
					if (two_data(es[t])) begin
						ph[t] = PH_DATA2;
					end else begin
						expected_q.push_back(channel_msg(t, es[t], b, 8'd0, 1'b0));
						ph[t] = PH_DELTA;
					end
				end
			end
			PH_DATA1: begin
				hd[t] = b;
				if (two_data(es[t])) begin
					ph[t] = PH_DATA2;
				end else begin
					expected_q.push_back(channel_msg(t, es[t], b, 8'd0, 1'b0));
					ph[t] = PH_DELTA;
				end
			end
			PH_DATA2: begin
				expected_q.push_back(channel_msg(t, es[t], hd[t], b, 1'b1));
				ph[t] = PH_DELTA;
			end
			PH_META_TYPE: begin
				mk[t] = b;
				acc[t] = 0;
				ph[t] = PH_META_LEN;
			end
			PH_META_LEN: begin
				acc[t] = (acc[t] << 7) | 32'(b[6:0]);
				if (!b[7]) begin
					len = acc[t];
					acc[t] = 0;
					if (mk[t] == META_TEMPO) begin
						skp[t] = 3;
						ph[t] = PH_TEMPO;
					end else if (mk[t] == META_EOT) begin
						r.kind = KIND_END;
						expected_q.push_back(r);
						ph[t] = PH_ENDED;
					end else begin
						take_length(t, len);
					end
				end
			end
			PH_SYSEX_LEN: begin
				acc[t] = (acc[t] << 7) | 32'(b[6:0]);
				if (!b[7]) begin
					len = acc[t];
					acc[t] = 0;
					take_length(t, len);
				end
			end
			PH_SKIP: begin
				skp[t] = skp[t] - 1;
				if (skp[t] == 0)
					ph[t] = PH_DELTA;
			end
			PH_TEMPO: begin
				acc[t] = ((acc[t] << 8) | 32'(b)) & 32'h00FF_FFFF;
				skp[t] = skp[t] - 1;
				if (skp[t] == 0) begin
					tmp[t] = acc[t][23:0];
					acc[t] = 0;
					ph[t] = PH_DELTA;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		event_res_t e, a;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				ph[i] = PH_ENDED; acc[i] = 0; skp[i] = 0; rs[i] = 0;
				es[i] = 0; mk[i] = 0; hd[i] = 0; tmp[i] = TEMPO_RST;
			end
			tpq = 15'd96;
			tsc = 11'd256;
			vsc = 12'd256;
			expected_q.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TICKS: tpq = cfg_data[14:0];
					REG_TEMPO: tsc = cfg_data[10:0];
					REG_VOL:   vsc = cfg_data[11:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				a = '{kind, track_out, status_code, first_data, second_data, has_second,
					delay_ms};
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %h", a);
				end else begin
					e = expected_q.pop_front();
					if (a != e) begin
						errors++;
						if (errors <= 10)
							$display("mismatch exp kind %0d trk %0d st %h d1 %h d2 %h two %0d dly %0d, got kind %0d trk %0d st %h d1 %h d2 %h two %0d dly %0d",
								e.kind, e.trk, e.st, e.d1, e.d2, e.two, e.dly,
								a.kind, a.trk, a.st, a.d1, a.d2, a.two, a.dly);
					end
				end
			end
			if (in_valid && in_ready)
				predict_byte(track, data_byte, track_start);
		end
		pending = expected_q.size();
	end

endmodule

// File: dv/tb_top.sv
// top of the midi track event parser testbench: clock, reset, stimulus and verdict
// depends on mtep_pkg, midi_track_event_parser_unit and mtep_checker
`timescale 1ns / 1ps

module tb_top;
	import mtep_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE     = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_TICKS;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  track = '0;
	logic [7:0]  data_byte = '0;
	logic        track_start = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [3:0]  track_out;
	logic [7:0]  status_code, first_data, second_data;
	logic        has_second;
	logic [31:0] delay_ms;
	int          pending, errors;

	// stimulus-side view of each track: live once started, queued bytes {start, byte}
	logic        live [16];
	logic [8:0]  trk_bytes [16][$];
	logic        calm = 1'b0;       // no idling on either side while set
	logic        long_hold = 1'b0;  // receiver holds off for a long stretch
	int          idle_cycles = 0;

	always #1 clk = ~clk;

	midi_track_event_parser_unit uut (.*);

	mtep_checker chk (.*);

	// gap lengths: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// receiver side: random stalls plus the one long hold-off
	initial begin
		int gap;
		gap = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 1'b0;
			end else if (gap > 0) begin
				out_ready <= 1'b0;
				gap--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 7) == 0)
					gap = pick_gap();
			end
		end
	end

	// watchdog on cycles where no channel moves a request
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("midi_track_event_parser_unit test failed");
				$finish;
			end
		end
	end

	// one byte request; valid stays high across back-to-back requests
	task automatic send_byte(logic [3:0] t, logic [7:0] b, logic s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		track <= t;
		data_byte <= b;
		track_start <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// registers change only with the block drained and settled
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push(logic [3:0] t, logic [7:0] b, logic s = 1'b0);
		trk_bytes[t].push_back({s, b});
	endtask

	// delta time as a varlen of 1..5 bytes, five bytes wrap the accumulator
	task automatic push_delta(logic [3:0] t, logic s);
		int n, r;
		r = $urandom_range(0, 99);
		n = (r < 70) ? 1 : (r < 85) ? 2 : (r < 97) ? $urandom_range(3, 4) : 5;
		for (int i = 1; i < n; i++) begin
			push(t, 8'h80 | 8'($urandom_range(0, 127)), s);
			s = 1'b0;
		end
		push(t, 8'($urandom_range(0, 127)), s);
	endtask

	// next well-formed event of a track, with some noise and broken input mixed in
	task automatic add_event(logic [3:0] t);
		int r, n;
		logic [7:0] ch;
		if (!live[t] || $urandom_range(0, 49) == 0) begin
			if (!live[t] && $urandom_range(0, 4) == 0)
				push(t, 8'($urandom()));          // ignored by an ended track
			push_delta(t, 1'b1);
			live[t] = 1'b1;
		end else begin
			push_delta(t, 1'b0);
		end
		ch = 8'($urandom_range(0, 15));
		r = $urandom_range(0, 99);
		if (r < 30) begin
			n = $urandom_range(0, 2);
			push(t, (n == 0 ? 8'h80 : n == 1 ? 8'h90 : 8'hE0) | ch);
			push(t, 8'($urandom_range(0, 127)));
			push(t, 8'($urandom_range(0, 127)));
		end else if (r < 45) begin
			// running status, one or two data bytes depending on the status held
			push(t, 8'($urandom_range(0, 127)));
			push(t, 8'($urandom_range(0, 127)));
		end else if (r < 53) begin
			push(t, ($urandom_range(0, 1) ? 8'hC0 : 8'hD0) | ch);
			push(t, 8'($urandom()));
		end else if (r < 63) begin
			push(t, 8'hB0 | ch);
			push(t, $urandom_range(0, 3) ? CC_VOLUME : 8'($urandom_range(0, 127)));
			push(t, 8'($urandom()));
		end else if (r < 70) begin
			push(t, META_ESC);
			push(t, META_TEMPO);
			push(t, $urandom_range(0, 3) ? 8'd3 : 8'($urandom_range(0, 127)));
			for (int i = 0; i < 3; i++) push(t, 8'($urandom()));
		end else if (r < 76) begin
			n = $urandom_range(0, 5);
			push(t, META_ESC);
			push(t, 8'($urandom_range(0, 127)));
			push(t, 8'(n));
			for (int i = 0; i < n; i++) push(t, 8'($urandom()));
		end else if (r < 82) begin
			n = $urandom_range(0, 4);
			push(t, $urandom_range(0, 1) ? 8'hF0 : 8'hF7);
			push(t, 8'(n));
			for (int i = 0; i < n; i++) push(t, 8'($urandom()));
		end else if (r < 86) begin
			push(t, META_ESC);
			push(t, META_EOT);
			push(t, 8'd0);
			live[t] = 1'b0;
		end else begin
			push(t, 8'($urandom()));
		end
	endtask

	initial begin
		logic [8:0] nb;
		logic [3:0] t;
		for (int i = 0; i < 16; i++) live[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: notes, running status, one-data message, volume, tempo, saturation,
		// zero-length sysex, end of track, ended track, status never set
		calm = 1'b1;
		send_byte(4'd0, 8'h00, 1'b1);
		send_byte(4'd0, 8'h90, 1'b0); send_byte(4'd0, 8'h3C, 1'b0);
		send_byte(4'd0, 8'h7F, 1'b0);
		send_byte(4'd0, 8'h81, 1'b0); send_byte(4'd0, 8'h00, 1'b0);
		send_byte(4'd0, 8'h40, 1'b0); send_byte(4'd0, 8'h00, 1'b0);
		send_byte(4'd0, 8'h00, 1'b0);
		send_byte(4'd0, 8'hC5, 1'b0); send_byte(4'd0, 8'hFF, 1'b0);
		send_byte(4'd0, 8'h00, 1'b0);
		send_byte(4'd0, 8'hB0, 1'b0); send_byte(4'd0, CC_VOLUME, 1'b0);
		send_byte(4'd0, 8'hFF, 1'b0);
		send_byte(4'd0, 8'h00, 1'b0);
		send_byte(4'd0, META_ESC, 1'b0); send_byte(4'd0, META_TEMPO, 1'b0);
		send_byte(4'd0, 8'h03, 1'b0);
		send_byte(4'd0, 8'hFF, 1'b0); send_byte(4'd0, 8'hFF, 1'b0);
		send_byte(4'd0, 8'hFF, 1'b0);
		send_byte(4'd0, 8'hFF, 1'b0); send_byte(4'd0, 8'hFF, 1'b0);
		send_byte(4'd0, 8'hFF, 1'b0); send_byte(4'd0, 8'h7F, 1'b0);
		send_byte(4'd0, 8'hF0, 1'b0); send_byte(4'd0, 8'h00, 1'b0);
		send_byte(4'd0, 8'h00, 1'b0);
		send_byte(4'd0, META_ESC, 1'b0); send_byte(4'd0, META_EOT, 1'b0);
		send_byte(4'd0, 8'h00, 1'b0);
		send_byte(4'd0, 8'h55, 1'b0);
		send_byte(4'd15, 8'h00, 1'b1);
		send_byte(4'd15, 8'h12, 1'b0); send_byte(4'd15, 8'h34, 1'b0);
		calm = 1'b0;

		// random phases, each under its own register setting
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: begin write_reg(REG_TICKS, 16'd480); write_reg(REG_TEMPO, 16'd256);
					write_reg(REG_VOL, 16'd384); end
				1: begin write_reg(REG_TICKS, 16'd1); write_reg(REG_TEMPO, 16'd32);
					write_reg(REG_VOL, 16'd4095); end
				2: begin write_reg(REG_TICKS, 16'd32767); write_reg(REG_TEMPO, 16'd1280);
					write_reg(REG_VOL, 16'd0); end
				3: begin write_reg(REG_TICKS, 16'd0); end
				4: begin write_reg(REG_TICKS, 16'd96); write_reg(REG_TEMPO, 16'd0); end
				5: begin write_reg(REG_TEMPO, 16'($urandom_range(32, 1280)));
					write_reg(REG_TICKS, 16'($urandom_range(1, 32767)));
					write_reg(REG_VOL, 16'($urandom_range(0, 4095))); end
				default: begin write_reg(REG_TICKS, 16'hFFFF); write_reg(REG_TEMPO, 16'hFFFF);
					write_reg(REG_VOL, 16'hFFFF); end
			endcase
			calm = (p == 2);
			if (p == 1)
				long_hold = 1'b1;
			for (int i = 0; i < 215; i++) begin
				t = (p == 5) ? 4'($urandom_range(0, 2)) : 4'($urandom_range(0, 15));
				if (trk_bytes[t].size() == 0)
					add_event(t);
				nb = trk_bytes[t].pop_front();
				send_byte(t, nb[7:0], nb[8]);
			end
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("midi_track_event_parser_unit test passed");
		else
			$display("midi_track_event_parser_unit test failed");
		$finish;
	end

endmodule
